### hw/rtl/ttdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdn_pkg
// Shared types, widths and date tables for the timestamp to day number core.
// ----------------------------------------------------------------------------
package ttdn_pkg;

  localparam int DAY_W  = 22;
  localparam int SEC_W  = 19;
  localparam int YEAR_W = 14;
  localparam int DBM_W  = 9;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [6:0] MONTH_FIRST = 7'd1;
  localparam logic [6:0] MONTH_LAST  = 7'd12;

  // one timestamp as received, ascii digits with the first character high
  typedef struct packed {
    logic [31:0] year_chars;
    logic [15:0] month_chars;
    logic [15:0] day_chars;
    logic [15:0] hour_chars;
    logic [15:0] minute_chars;
    logic [15:0] second_chars;
  } ts_t;

  typedef struct packed {
    logic [DAY_W-1:0] day_number;
    logic [SEC_W-1:0] seconds_of_day;
    logic             bad_input;
  } res_t;

  function automatic logic digit_ok(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    v = c - CHAR_ZERO;
    return v[3:0];
  endfunction

  // two ascii digits to a binary value 0..99
  function automatic logic [6:0] two_digit(input logic [15:0] cc);
    logic [6:0] hi;
    logic [6:0] lo;
    hi = {3'b000, digit_val(cc[15:8])};
    lo = {3'b000, digit_val(cc[7:0])};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  function automatic logic two_ok(input logic [15:0] cc);
    return digit_ok(cc[15:8]) && digit_ok(cc[7:0]);
  endfunction

  // days before month m (1..12), leap selects the leap-year row
  function automatic logic [DBM_W-1:0] days_before_month(input logic leap,
                                                          input logic [3:0] m);
    logic [DBM_W-1:0] base;
    logic [DBM_W-1:0] extra;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    extra = (leap && (m > 4'd2)) ? 9'd1 : 9'd0;
    return base + extra;
  endfunction

endpackage

### hw/rtl/ttdn_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdn_calc
// Digit decode, leap-year count and day/second sums for one timestamp.
// ----------------------------------------------------------------------------
module ttdn_calc import ttdn_pkg::*; (
  input  ts_t  ts,
  output res_t res
);

  logic [6:0]        cent;
  logic [6:0]        yr_lo;
  logic [6:0]        month;
  logic [6:0]        day;
  logic [6:0]        hour;
  logic [6:0]        minute;
  logic [6:0]        second;
  logic [YEAR_W-1:0] year;
  logic [YEAR_W-1:0] leaps;
  logic [YEAR_W-1:0] div4_up;
  logic [YEAR_W-1:0] div100_up;
  logic [YEAR_W-1:0] div400_up;
  logic              lo_zero;
  logic              leap;
  logic              chars_ok;
  logic              month_ok;
  logic [DBM_W-1:0]  dbm;
  logic [DAY_W-1:0]  days;
  logic [SEC_W-1:0]  secs;

  always_comb begin
    cent   = two_digit(ts.year_chars[31:16]);
    yr_lo  = two_digit(ts.year_chars[15:0]);
    month  = two_digit(ts.month_chars);
    day    = two_digit(ts.day_chars);
    hour   = two_digit(ts.hour_chars);
    minute = two_digit(ts.minute_chars);
    second = two_digit(ts.second_chars);

    chars_ok = two_ok(ts.year_chars[31:16]) && two_ok(ts.year_chars[15:0]) &&
               two_ok(ts.month_chars) && two_ok(ts.day_chars) &&
               two_ok(ts.hour_chars) && two_ok(ts.minute_chars) &&
               two_ok(ts.second_chars);
    month_ok = (month >= MONTH_FIRST) && (month <= MONTH_LAST);

    year    = YEAR_W'(cent) * YEAR_W'(100) + YEAR_W'(yr_lo);
    lo_zero = (yr_lo == 7'd0);

    // year = 100*cent + yr_lo, so the ceilings over 100 and 400 follow from cent
    div4_up   = (year + YEAR_W'(3)) >> 2;
    div100_up = YEAR_W'(cent) + (lo_zero ? YEAR_W'(0) : YEAR_W'(1));
    div400_up = lo_zero ? ((YEAR_W'(cent) + YEAR_W'(3)) >> 2)
                        : ((YEAR_W'(cent) >> 2) + YEAR_W'(1));
    leaps     = div4_up - div100_up + div400_up;

    leap = lo_zero ? (cent[1:0] == 2'b00) : (yr_lo[1:0] == 2'b00);
    dbm  = days_before_month(leap, month[3:0]);

    days = DAY_W'(year) * DAY_W'(365) + DAY_W'(leaps) + DAY_W'(dbm) + DAY_W'(day);
    secs = SEC_W'(hour) * SEC_W'(3600) + SEC_W'(minute) * SEC_W'(60) + SEC_W'(second);

    res.bad_input      = !(chars_ok && month_ok);
    res.day_number     = res.bad_input ? '0 : days;
    res.seconds_of_day = res.bad_input ? '0 : secs;
  end

endmodule

### hw/rtl/timestamp_to_day_number_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_day_number_core
// Gregorian day number and seconds of day from an ascii YYYYMMDDHHMMSS stamp.
// ----------------------------------------------------------------------------
// Takes one timestamp per cycle while in_stall is low, holds it in the input
// register and passes it through the decode and arithmetic into the output
// register. Throughput is one transaction per clock when out_stall is low, set
// by the single calculation stage between those registers; out_stall holds both
// stages and backs up into in_stall only when both are full.
// day_number counts days from year 0 (a leap year) through the given day,
// seconds_of_day is h*3600+m*60+s. A non-digit character or a month outside
// 1..12 raises bad_input with both numbers zero; day, hour, minute and second
// are not range checked.
module timestamp_to_day_number_core import ttdn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_year_chars,
  input  logic [15:0]      in_month_chars,
  input  logic [15:0]      in_day_chars,
  input  logic [15:0]      in_hour_chars,
  input  logic [15:0]      in_minute_chars,
  input  logic [15:0]      in_second_chars,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DAY_W-1:0] out_day_number,
  output logic [SEC_W-1:0] out_seconds_of_day,
  output logic             out_bad_input
);

  ts_t  s1_ts_r;
  logic s1_valid_r;
  logic s1_valid_nxt;
  res_t calc_res;
  res_t s2_res_r;
  logic s2_valid_r;
  logic s2_valid_nxt;
  logic s2_adv;
  logic s1_adv;

  ttdn_calc u_calc (
    .ts  (s1_ts_r),
    .res (calc_res)
  );

  always_comb begin
    s2_adv       = !s2_valid_r || !out_stall;
    s1_adv       = !s1_valid_r || s2_adv;
    in_stall     = !s1_adv;
    s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_ts_r.year_chars   <= in_year_chars;
      s1_ts_r.month_chars  <= in_month_chars;
      s1_ts_r.day_chars    <= in_day_chars;
      s1_ts_r.hour_chars   <= in_hour_chars;
      s1_ts_r.minute_chars <= in_minute_chars;
      s1_ts_r.second_chars <= in_second_chars;
    end
    if (s2_adv && s1_valid_r) begin
      s2_res_r <= calc_res;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_day_number     = s2_res_r.day_number;
  assign out_seconds_of_day = s2_res_r.seconds_of_day;
  assign out_bad_input      = s2_res_r.bad_input;

endmodule
